FILE: design/tha_pkg.sv
// Shared types, constants and saturating fixed-point helpers for the halo acceleration core.
package tha_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IW         = 64;
  localparam int IW2        = 2 * IW;
  localparam int HW         = IW / 2;
  localparam int MUL_LAT    = 5;
  localparam int DIV_STEPS  = IW2;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [IW-1:0]         fx_t;
  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef struct packed {
    logic clip;
    fx_t  val;
  } fx_res_t;

  typedef struct packed {
    logic  clip;
    word_t val;
  } wd_res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VEL  = 3'd0,
    CFG_FLAT = 3'd1,
    CFG_SCL  = 3'd2,
    CFG_C1   = 3'd3,
    CFG_C2   = 3'd4,
    CFG_C3   = 3'd5
  } cfg_idx_t;

  localparam word_t RST_VEL  = WORD_WIDTH'(4784128);
  localparam word_t RST_FLAT = WORD_WIDTH'(65536);
  localparam word_t RST_SCL  = WORD_WIDTH'(786432);
  localparam word_t RST_C1   = WORD_WIDTH'(65536);
  localparam word_t RST_C2   = WORD_WIDTH'(65536);
  localparam word_t RST_C3   = WORD_WIDTH'(0);

  localparam fx_t FX_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(IW-1){1'b0}}};
  localparam word_t WD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam logic [IW2-1:0] MAG_TOP = {{IW{1'b0}}, 1'b1, {(IW-1){1'b0}}};

  function automatic fx_t sx(input word_t w);
    return {{(IW-WORD_WIDTH){w[WORD_WIDTH-1]}}, w};
  endfunction

  function automatic logic [IW-1:0] fx_mag(input fx_t a);
    return a[IW-1] ? ({IW{1'b0}} - a) : a;
  endfunction

  function automatic fx_res_t fx_pack(input logic neg, input logic [IW2-1:0] mag);
    fx_res_t r;
    r.clip = 1'b0;
    if (neg) begin
      if (mag > MAG_TOP) begin
        r.clip = 1'b1;
        r.val  = FX_MIN;
      end else begin
        r.val = {IW{1'b0}} - mag[IW-1:0];
      end
    end else if (mag > MAG_TOP - 1) begin
      r.clip = 1'b1;
      r.val  = FX_MAX;
    end else begin
      r.val = mag[IW-1:0];
    end
    return r;
  endfunction

  function automatic fx_res_t fx_add(input fx_t a, input fx_t b);
    fx_res_t      r;
    logic [IW:0]  s;
    s = {a[IW-1], a} + {b[IW-1], b};
    r.clip = s[IW] ^ s[IW-1];
    if (r.clip) begin
      r.val = s[IW] ? FX_MIN : FX_MAX;
    end else begin
      r.val = s[IW-1:0];
    end
    return r;
  endfunction

  function automatic fx_res_t fx_neg(input fx_t a);
    fx_res_t r;
    r.clip = (a == FX_MIN);
    r.val  = r.clip ? FX_MAX : ({IW{1'b0}} - a);
    return r;
  endfunction

  function automatic wd_res_t to_word(input fx_t a);
    wd_res_t r;
    r.clip = !((&a[IW-1:WORD_WIDTH-1]) || !(|a[IW-1:WORD_WIDTH-1]));
    if (r.clip) begin
      r.val = a[IW-1] ? WD_MIN : WD_MAX;
    end else begin
      r.val = a[WORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/tha_mul.sv
// Pipelined saturating fixed-point multiplier built from 32x32 partial products.
module tha_mul (
  input  logic             clk,
  input  tha_pkg::fx_t     a,
  input  tha_pkg::fx_t     b,
  output tha_pkg::fx_res_t res
);

  logic [tha_pkg::IW-1:0]  ma_r, mb_r;
  logic [tha_pkg::IW-1:0]  p00_r, p01_r, p10_r, p11_r;
  logic [tha_pkg::IW:0]    mid_r;
  logic [tha_pkg::IW-1:0]  lo_r, hi_r;
  logic [tha_pkg::IW2-1:0] full_r;
  logic [3:0]              neg_r;
  tha_pkg::fx_res_t        res_r;

  always_ff @(posedge clk) begin
    ma_r     <= tha_pkg::fx_mag(a);
    mb_r     <= tha_pkg::fx_mag(b);
    neg_r[0] <= a[tha_pkg::IW-1] ^ b[tha_pkg::IW-1];
    p00_r    <= ma_r[tha_pkg::HW-1:0] * mb_r[tha_pkg::HW-1:0];
    p01_r    <= ma_r[tha_pkg::HW-1:0] * mb_r[tha_pkg::IW-1:tha_pkg::HW];
    p10_r    <= ma_r[tha_pkg::IW-1:tha_pkg::HW] * mb_r[tha_pkg::HW-1:0];
    p11_r    <= ma_r[tha_pkg::IW-1:tha_pkg::HW] * mb_r[tha_pkg::IW-1:tha_pkg::HW];
    neg_r[1] <= neg_r[0];
    mid_r    <= {1'b0, p01_r} + {1'b0, p10_r};
    lo_r     <= p00_r;
    hi_r     <= p11_r;
    neg_r[2] <= neg_r[1];
    full_r   <= {hi_r, lo_r} + {{(tha_pkg::HW-1){1'b0}}, mid_r, {tha_pkg::HW{1'b0}}};
    neg_r[3] <= neg_r[2];
    res_r    <= tha_pkg::fx_pack(neg_r[3], full_r >> tha_pkg::FRAC_BITS);
  end

  assign res = res_r;

endmodule

FILE: design/tha_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating fixed-point result.
module tha_div (
  input  logic             clk,
  input  tha_pkg::fx_t     n,
  input  tha_pkg::fx_t     d,
  output tha_pkg::fx_res_t res,
  output logic             dz
);

  localparam int S = tha_pkg::DIV_STEPS;

  logic [tha_pkg::IW-1:0]  dm_r  [0:S];
  logic [tha_pkg::IW-1:0]  rem_r [0:S];
  logic [tha_pkg::IW2-1:0] nq_r  [0:S];
  logic                    neg_r [0:S];
  logic                    dz_r  [0:S];
  tha_pkg::fx_res_t        res_r;
  logic                    dz_out_r;

  always_ff @(posedge clk) begin
    dm_r[0]  <= tha_pkg::fx_mag(d);
    rem_r[0] <= '0;
    nq_r[0]  <= {{tha_pkg::IW{1'b0}}, tha_pkg::fx_mag(n)} << tha_pkg::FRAC_BITS;
    neg_r[0] <= n[tha_pkg::IW-1] ^ d[tha_pkg::IW-1];
    dz_r[0]  <= (d == '0);
  end

  for (genvar k = 0; k < S; k++) begin : g_step
    logic [tha_pkg::IW:0] trial;
    logic [tha_pkg::IW:0] diff;
    logic                 take;
    assign trial = {rem_r[k], nq_r[k][tha_pkg::IW2-1]};
    assign diff  = trial - {1'b0, dm_r[k]};
    assign take  = trial >= {1'b0, dm_r[k]};
    always_ff @(posedge clk) begin
      rem_r[k+1] <= take ? diff[tha_pkg::IW-1:0] : trial[tha_pkg::IW-1:0];
      nq_r[k+1]  <= {nq_r[k][tha_pkg::IW2-2:0], take};
      dm_r[k+1]  <= dm_r[k];
      neg_r[k+1] <= neg_r[k];
      dz_r[k+1]  <= dz_r[k];
    end
  end

  always_ff @(posedge clk) begin
    dz_out_r <= dz_r[S];
    if (dz_r[S]) begin
      res_r <= '0;
    end else begin
      res_r <= tha_pkg::fx_pack(neg_r[S], nq_r[S]);
    end
  end

  assign res = res_r;
  assign dz  = dz_out_r;

endmodule

FILE: design/triaxial_halo_accel_core.sv
// Top level: triaxial logarithmic halo acceleration pipeline.
// Throughput: one request per cycle; busy is always low and nothing stalls.
// The longest path is the chain multiply, divide (z^2/q^2), add, divide.
// Reset clears the valid pipeline and loads the default halo configuration.
module triaxial_halo_accel_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tha_pkg::WORD_WIDTH-1:0] in_pos_x,
  input  logic signed [tha_pkg::WORD_WIDTH-1:0] in_pos_y,
  input  logic signed [tha_pkg::WORD_WIDTH-1:0] in_pos_z,
  output logic                                out_valid,
  output logic signed [tha_pkg::WORD_WIDTH-1:0] out_acc_x,
  output logic signed [tha_pkg::WORD_WIDTH-1:0] out_acc_y,
  output logic signed [tha_pkg::WORD_WIDTH-1:0] out_acc_z,
  output logic                                out_saturated,
  output logic                                out_div_zero,
  input  logic                                cfg_we,
  input  logic [tha_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [tha_pkg::WORD_WIDTH-1:0]      cfg_wdata
);

  localparam int T_C11 = 1;
  localparam int T_M1  = tha_pkg::MUL_LAT;
  localparam int T_MV  = T_M1 + 1;
  localparam int T_MV2 = T_MV + 1;
  localparam int T_M2  = T_M1 + tha_pkg::MUL_LAT;
  localparam int T_A1  = T_M2 + 1;
  localparam int T_AP  = T_A1 + 1;
  localparam int T_A   = T_AP + 1;
  localparam int T_MVZ = T_MV2 + tha_pkg::MUL_LAT;
  localparam int T_MN  = T_A1 + tha_pkg::MUL_LAT;
  localparam int T_QA  = T_A + tha_pkg::MUL_LAT;
  localparam int T_DZ  = T_QA + 1;
  localparam int T_ZQ  = T_M1 + tha_pkg::DIV_LAT;
  localparam int T_A2  = T_ZQ + 1;
  localparam int T_AZ  = T_DZ + tha_pkg::DIV_LAT;
  localparam int T_AX  = T_A2 + tha_pkg::DIV_LAT;

  // configuration
  tha_pkg::word_t cfg_vel_r, cfg_flat_r, cfg_scl_r, cfg_c1_r, cfg_c2_r, cfg_c3_r;
  tha_pkg::fx_t   cv, cq, cd, c1, c2, c3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_vel_r  <= tha_pkg::RST_VEL;
      cfg_flat_r <= tha_pkg::RST_FLAT;
      cfg_scl_r  <= tha_pkg::RST_SCL;
      cfg_c1_r   <= tha_pkg::RST_C1;
      cfg_c2_r   <= tha_pkg::RST_C2;
      cfg_c3_r   <= tha_pkg::RST_C3;
    end else if (cfg_we) begin
      case (tha_pkg::cfg_idx_t'(cfg_idx))
        tha_pkg::CFG_VEL:  cfg_vel_r  <= cfg_wdata;
        tha_pkg::CFG_FLAT: cfg_flat_r <= cfg_wdata;
        tha_pkg::CFG_SCL:  cfg_scl_r  <= cfg_wdata;
        tha_pkg::CFG_C1:   cfg_c1_r   <= cfg_wdata;
        tha_pkg::CFG_C2:   cfg_c2_r   <= cfg_wdata;
        tha_pkg::CFG_C3:   cfg_c3_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cv = tha_pkg::sx(cfg_vel_r);
  assign cq = tha_pkg::sx(cfg_flat_r);
  assign cd = tha_pkg::sx(cfg_scl_r);
  assign c1 = tha_pkg::sx(cfg_c1_r);
  assign c2 = tha_pkg::sx(cfg_c2_r);
  assign c3 = tha_pkg::sx(cfg_c3_r);

  assign busy = 1'b0;

  // data pipeline
  tha_pkg::fx_t x_r [0:T_M1];
  tha_pkg::fx_t y_r [0:T_M1];
  tha_pkg::fx_t z_r [0:T_MV2];
  tha_pkg::fx_t c11_r [T_C11+1:T_M1];
  tha_pkg::fx_t c22_r [T_C11+1:T_M1];
  tha_pkg::fx_t mv_r [T_MV+1:T_A1];
  tha_pkg::fx_t dd_r [T_M1+1:T_M2];
  tha_pkg::fx_t c3x_r [T_M1+1:T_M2];
  tha_pkg::fx_t c3y_r [T_M1+1:T_M2];
  tha_pkg::fx_t zz_r [T_M1+1:T_QA];
  tha_pkg::fx_t qq_r [T_M1+1:T_A];
  tha_pkg::fx_t c2yy_r [T_M2+1:T_AP];
  tha_pkg::fx_t c3xy_r [T_M2+1:T_A1];
  tha_pkg::fx_t a_r [T_A+1:T_ZQ];
  tha_pkg::fx_t mnx_r [T_MN+1:T_A2];
  tha_pkg::fx_t mny_r [T_MN+1:T_A2];
  tha_pkg::fx_t mvz_r [T_MVZ+1:T_DZ];
  tha_pkg::fx_t az_r [T_AZ+1:T_AX];
  logic         azdz_r [T_AZ+1:T_AX];
  logic         qz_r [T_ZQ+1:T_AX];

  tha_pkg::fx_res_t c11_s_r, c22_s_r, mv_s_r, mv2_s_r, a1_s_r, nx_s_r, ny_s_r;
  tha_pkg::fx_res_t ap_s_r, a_s_r, denz_s_r, a2_s_r;

  tha_pkg::fx_res_t qq_w, dd_w, vv_w, xx_w, yy_w, zz_w, c3x_w, c3y_w;
  tha_pkg::fx_res_t c1xx_w, c2yy_w, c3xy_w, c11x_w, c22y_w;
  tha_pkg::fx_res_t mvz_w, mnx_w, mny_w, qa_w;
  tha_pkg::fx_res_t zq_w, az_w, ax_w, ay_w;
  logic             zq_dz, az_dz, ax_dz, ay_dz;

  tha_mul u_qq   (.clk(clk), .a(cq),         .b(cq),          .res(qq_w));
  tha_mul u_dd   (.clk(clk), .a(cd),         .b(cd),          .res(dd_w));
  tha_mul u_vv   (.clk(clk), .a(cv),         .b(cv),          .res(vv_w));
  tha_mul u_xx   (.clk(clk), .a(x_r[0]),     .b(x_r[0]),      .res(xx_w));
  tha_mul u_yy   (.clk(clk), .a(y_r[0]),     .b(y_r[0]),      .res(yy_w));
  tha_mul u_zz   (.clk(clk), .a(z_r[0]),     .b(z_r[0]),      .res(zz_w));
  tha_mul u_c3x  (.clk(clk), .a(c3),         .b(x_r[0]),      .res(c3x_w));
  tha_mul u_c3y  (.clk(clk), .a(c3),         .b(y_r[0]),      .res(c3y_w));
  tha_mul u_c1xx (.clk(clk), .a(c1),         .b(xx_w.val),    .res(c1xx_w));
  tha_mul u_c2yy (.clk(clk), .a(c2),         .b(yy_w.val),    .res(c2yy_w));
  tha_mul u_c3xy (.clk(clk), .a(c3x_w.val),  .b(y_r[T_M1]),   .res(c3xy_w));
  tha_mul u_c11x (.clk(clk), .a(c11_r[T_M1]), .b(x_r[T_M1]),  .res(c11x_w));
  tha_mul u_c22y (.clk(clk), .a(c22_r[T_M1]), .b(y_r[T_M1]),  .res(c22y_w));
  tha_mul u_mvz  (.clk(clk), .a(mv2_s_r.val), .b(z_r[T_MV2]), .res(mvz_w));
  tha_mul u_mnx  (.clk(clk), .a(mv_r[T_A1]), .b(nx_s_r.val),  .res(mnx_w));
  tha_mul u_mny  (.clk(clk), .a(mv_r[T_A1]), .b(ny_s_r.val),  .res(mny_w));
  tha_mul u_qa   (.clk(clk), .a(qq_r[T_A]),  .b(a_s_r.val),   .res(qa_w));

  tha_div u_zq (.clk(clk), .n(zz_w.val),     .d(qq_w.val),     .res(zq_w), .dz(zq_dz));
  tha_div u_az (.clk(clk), .n(mvz_r[T_DZ]),  .d(denz_s_r.val), .res(az_w), .dz(az_dz));
  tha_div u_ax (.clk(clk), .n(mnx_r[T_A2]),  .d(a2_s_r.val),   .res(ax_w), .dz(ax_dz));
  tha_div u_ay (.clk(clk), .n(mny_r[T_A2]),  .d(a2_s_r.val),   .res(ay_w), .dz(ay_dz));

  always_ff @(posedge clk) begin
    x_r[0] <= tha_pkg::sx(in_pos_x);
    y_r[0] <= tha_pkg::sx(in_pos_y);
    z_r[0] <= tha_pkg::sx(in_pos_z);
    for (int k = 1; k <= T_M1; k++) begin
      x_r[k] <= x_r[k-1];
      y_r[k] <= y_r[k-1];
    end
    for (int k = 1; k <= T_MV2; k++) z_r[k] <= z_r[k-1];

    c11_s_r <= tha_pkg::fx_add(c1, c1);
    c22_s_r <= tha_pkg::fx_add(c2, c2);
    c11_r[T_C11+1] <= c11_s_r.val;
    c22_r[T_C11+1] <= c22_s_r.val;
    for (int k = T_C11+2; k <= T_M1; k++) begin
      c11_r[k] <= c11_r[k-1];
      c22_r[k] <= c22_r[k-1];
    end

    mv_s_r  <= tha_pkg::fx_neg(vv_w.val);
    mv2_s_r <= tha_pkg::fx_add(mv_s_r.val, mv_s_r.val);
    mv_r[T_MV+1] <= mv_s_r.val;
    for (int k = T_MV+2; k <= T_A1; k++) mv_r[k] <= mv_r[k-1];

    dd_r[T_M1+1]  <= dd_w.val;
    c3x_r[T_M1+1] <= c3x_w.val;
    c3y_r[T_M1+1] <= c3y_w.val;
    for (int k = T_M1+2; k <= T_M2; k++) begin
      dd_r[k]  <= dd_r[k-1];
      c3x_r[k] <= c3x_r[k-1];
      c3y_r[k] <= c3y_r[k-1];
    end
    zz_r[T_M1+1] <= zz_w.val;
    for (int k = T_M1+2; k <= T_QA; k++) zz_r[k] <= zz_r[k-1];
    qq_r[T_M1+1] <= qq_w.val;
    for (int k = T_M1+2; k <= T_A; k++) qq_r[k] <= qq_r[k-1];

    c2yy_r[T_M2+1] <= c2yy_w.val;
    for (int k = T_M2+2; k <= T_AP; k++) c2yy_r[k] <= c2yy_r[k-1];
    c3xy_r[T_M2+1] <= c3xy_w.val;
    for (int k = T_M2+2; k <= T_A1; k++) c3xy_r[k] <= c3xy_r[k-1];

    a1_s_r <= tha_pkg::fx_add(dd_r[T_M2], c1xx_w.val);
    nx_s_r <= tha_pkg::fx_add(c11x_w.val, c3y_r[T_M2]);
    ny_s_r <= tha_pkg::fx_add(c22y_w.val, c3x_r[T_M2]);
    ap_s_r <= tha_pkg::fx_add(a1_s_r.val, c3xy_r[T_A1]);
    a_s_r  <= tha_pkg::fx_add(ap_s_r.val, c2yy_r[T_AP]);
    a_r[T_A+1] <= a_s_r.val;
    for (int k = T_A+2; k <= T_ZQ; k++) a_r[k] <= a_r[k-1];

    mvz_r[T_MVZ+1] <= mvz_w.val;
    for (int k = T_MVZ+2; k <= T_DZ; k++) mvz_r[k] <= mvz_r[k-1];
    denz_s_r <= tha_pkg::fx_add(qa_w.val, zz_r[T_QA]);

    mnx_r[T_MN+1] <= mnx_w.val;
    mny_r[T_MN+1] <= mny_w.val;
    for (int k = T_MN+2; k <= T_A2; k++) begin
      mnx_r[k] <= mnx_r[k-1];
      mny_r[k] <= mny_r[k-1];
    end
    a2_s_r <= tha_pkg::fx_add(zq_w.val, a_r[T_ZQ]);

    qz_r[T_ZQ+1] <= zq_dz;
    for (int k = T_ZQ+2; k <= T_AX; k++) qz_r[k] <= qz_r[k-1];
    az_r[T_AZ+1]   <= az_w.val;
    azdz_r[T_AZ+1] <= az_dz;
    for (int k = T_AZ+2; k <= T_AX; k++) begin
      az_r[k]   <= az_r[k-1];
      azdz_r[k] <= azdz_r[k-1];
    end
  end

  // clip events: ev_a always counts, ev_b only when q^2 is nonzero
  logic ev_a [0:T_AX];
  logic ev_b [0:T_AX];
  logic acca_r [1:T_AX];
  logic accb_r [1:T_AX];

  always_comb begin
    for (int t = 0; t <= T_AX; t++) begin
      ev_a[t] = 1'b0;
      ev_b[t] = 1'b0;
    end
    ev_b[T_C11] = ev_b[T_C11] | c11_s_r.clip | c22_s_r.clip;
    ev_a[T_M1]  = ev_a[T_M1] | qq_w.clip | dd_w.clip | vv_w.clip | xx_w.clip
                | yy_w.clip | zz_w.clip | c3x_w.clip;
    ev_b[T_M1]  = ev_b[T_M1] | c3y_w.clip;
    ev_a[T_MV]  = ev_a[T_MV] | mv_s_r.clip;
    ev_a[T_MV2] = ev_a[T_MV2] | mv2_s_r.clip;
    ev_a[T_M2]  = ev_a[T_M2] | c1xx_w.clip | c2yy_w.clip | c3xy_w.clip;
    ev_b[T_M2]  = ev_b[T_M2] | c11x_w.clip | c22y_w.clip;
    ev_a[T_A1]  = ev_a[T_A1] | a1_s_r.clip;
    ev_b[T_A1]  = ev_b[T_A1] | nx_s_r.clip | ny_s_r.clip;
    ev_a[T_AP]  = ev_a[T_AP] | ap_s_r.clip;
    ev_a[T_MVZ] = ev_a[T_MVZ] | mvz_w.clip;
    ev_a[T_A]   = ev_a[T_A] | a_s_r.clip;
    ev_b[T_MN]  = ev_b[T_MN] | mnx_w.clip | mny_w.clip;
    ev_a[T_QA]  = ev_a[T_QA] | qa_w.clip;
    ev_a[T_DZ]  = ev_a[T_DZ] | denz_s_r.clip;
    ev_a[T_ZQ]  = ev_a[T_ZQ] | zq_w.clip;
    ev_b[T_A2]  = ev_b[T_A2] | a2_s_r.clip;
    ev_a[T_AZ]  = ev_a[T_AZ] | az_w.clip;
    ev_b[T_AX]  = ev_b[T_AX] | ax_w.clip | ay_w.clip;
  end

  always_ff @(posedge clk) begin
    acca_r[1] <= ev_a[0];
    accb_r[1] <= ev_b[0];
    for (int k = 2; k <= T_AX; k++) begin
      acca_r[k] <= acca_r[k-1] | ev_a[k-1];
      accb_r[k] <= accb_r[k-1] | ev_b[k-1];
    end
  end

  // final saturation and flags
  logic             qz;
  tha_pkg::fx_t     ax_v, ay_v;
  tha_pkg::wd_res_t twx, twy, twz;

  assign qz   = qz_r[T_AX];
  assign ax_v = qz ? '0 : ax_w.val;
  assign ay_v = qz ? '0 : ay_w.val;
  assign twx  = tha_pkg::to_word(ax_v);
  assign twy  = tha_pkg::to_word(ay_v);
  assign twz  = tha_pkg::to_word(az_r[T_AX]);

  logic [T_AX:0]  v_r;
  logic           out_valid_r;
  tha_pkg::word_t acc_x_r, acc_y_r, acc_z_r;
  logic           sat_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= {v_r[T_AX-1:0], start & ~busy};
      out_valid_r <= v_r[T_AX];
    end
  end

  always_ff @(posedge clk) begin
    acc_x_r <= twx.val;
    acc_y_r <= twy.val;
    acc_z_r <= twz.val;
    sat_r   <= acca_r[T_AX] | ev_a[T_AX] | twz.clip
             | (~qz & (accb_r[T_AX] | ev_b[T_AX] | twx.clip | twy.clip));
    dz_r    <= qz | azdz_r[T_AX] | (~qz & (ax_dz | ay_dz));
  end

  assign out_valid     = out_valid_r;
  assign out_acc_x     = acc_x_r;
  assign out_acc_y     = acc_y_r;
  assign out_acc_z     = acc_z_r;
  assign out_saturated = sat_r;
  assign out_div_zero  = dz_r;

endmodule
